// ===== hdl/rotated_sprite_source_mapper_macros.svh =====
// Assertion macros shared by the checker of the sprite source mapper.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ROTATED_SPRITE_SOURCE_MAPPER_MACROS_SVH
`define ROTATED_SPRITE_SOURCE_MAPPER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RSSM_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RSSM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/rssm_pkg.sv =====
// Types and fixed widths of the rotated sprite source mapper.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package rssm_pkg;

	// Configuration port.
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	// Register and field widths.
	localparam int TRIG_W  = 18;
	localparam int PIVOT_W = 12;
	localparam int SDIM_W  = 11;
	localparam int DDIM_W  = 12;
	localparam int COORD_W = 12;
	localparam int SRC_W   = 10;

	// Centered coordinate, one product and the rotation accumulator.
	localparam int CX_W   = COORD_W + 1;
	localparam int PROD_W = CX_W + TRIG_W;
	localparam int ACC_W  = PROD_W + 3;

	// Register indexes, word addressed.
	typedef enum logic [2:0] {
		REG_COS_ANGLE     = 3'd0,
		REG_SIN_ANGLE     = 3'd1,
		REG_PIVOT_X       = 3'd2,
		REG_PIVOT_Y       = 3'd3,
		REG_SOURCE_WIDTH  = 3'd4,
		REG_SOURCE_HEIGHT = 3'd5,
		REG_DEST_WIDTH    = 3'd6,
		REG_DEST_HEIGHT   = 3'd7
	} reg_idx_t;

	// The four rotation products of one pixel.
	typedef struct packed {
		logic signed [PROD_W-1:0] x_cos;
		logic signed [PROD_W-1:0] y_sin;
		logic signed [PROD_W-1:0] x_sin;
		logic signed [PROD_W-1:0] y_cos;
	} prod_t;

endpackage

// ===== hdl/rotated_sprite_source_mapper.sv =====
// Top level of the rotated sprite source mapper: registers, three-stage datapath.
// Depends on rssm_pkg.
//
// Usage:
// Each destination pixel request (dest_x, dest_y) on the in_valid/in_ready
// channel yields exactly one result (src_x, src_y, inside_res) on the
// out_valid/out_ready channel, in order. The pixel is centered on half the
// destination size, rotated by the cosine and sine registers, moved to the
// pivot and floored to whole source pixels; outside the source sprite the
// result is all zero.
// A request reaches out_valid through the input register, product register
// and result register. One request is accepted per cycle while the result
// channel is not stalled; the four 13x18 multipliers between the first two
// registers set the clock period, not the rate.
// When the receiver stalls, each stage holds and in_ready falls once every
// stage is full; no request is dropped.
// Reset empties the pipeline and loads cosine 1.0, sine 0, pivot 0, source
// size 1x1 and destination size 0x0; pready is always high. The user must write
// registers over the APB port only while no request is in flight; not enforced.
module rotated_sprite_source_mapper
	import rssm_pkg::*;
#(
	parameter int MAX_SOURCE_DIM = 1024,
	parameter int FRAC_BITS      = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// Request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_W-1:0]    dest_x,
	input  logic [COORD_W-1:0]    dest_y,
	// Result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SRC_W-1:0]      src_x,
	output logic [SRC_W-1:0]      src_y,
	output logic                  inside_res
);

	localparam int FRACUNIT = 1 << FRAC_BITS;
	localparam int MAXD_W   = $clog2(MAX_SOURCE_DIM + 1);
	localparam int DIM_W    = (MAXD_W > SDIM_W) ? MAXD_W : SDIM_W;
	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_SOURCE_DIM);

	// Configuration registers.
	logic signed [TRIG_W-1:0]  cos_angle_q;
	logic signed [TRIG_W-1:0]  sin_angle_q;
	logic signed [PIVOT_W-1:0] pivot_x_q;
	logic signed [PIVOT_W-1:0] pivot_y_q;
	logic [SDIM_W-1:0]         source_width_q;
	logic [SDIM_W-1:0]         source_height_q;
	logic [DDIM_W-1:0]         dest_width_q;
	logic [DDIM_W-1:0]         dest_height_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	// Register writes on the access cycle of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_angle_q     <= TRIG_W'(FRACUNIT);
			sin_angle_q     <= '0;
			pivot_x_q       <= '0;
			pivot_y_q       <= '0;
			source_width_q  <= SDIM_W'(1);
			source_height_q <= SDIM_W'(1);
			dest_width_q    <= '0;
			dest_height_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COS_ANGLE:     cos_angle_q     <= pwdata[TRIG_W-1:0];
				REG_SIN_ANGLE:     sin_angle_q     <= pwdata[TRIG_W-1:0];
				REG_PIVOT_X:       pivot_x_q       <= pwdata[PIVOT_W-1:0];
				REG_PIVOT_Y:       pivot_y_q       <= pwdata[PIVOT_W-1:0];
				REG_SOURCE_WIDTH:  source_width_q  <= pwdata[SDIM_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= pwdata[SDIM_W-1:0];
				REG_DEST_WIDTH:    dest_width_q    <= pwdata[DDIM_W-1:0];
				REG_DEST_HEIGHT:   dest_height_q   <= pwdata[DDIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback; signed registers read back sign extended.
	always_comb begin
		unique case (cfg_idx)
			REG_COS_ANGLE:     prdata = CFG_DATA_W'(cos_angle_q);
			REG_SIN_ANGLE:     prdata = CFG_DATA_W'(sin_angle_q);
			REG_PIVOT_X:       prdata = CFG_DATA_W'(pivot_x_q);
			REG_PIVOT_Y:       prdata = CFG_DATA_W'(pivot_y_q);
			REG_SOURCE_WIDTH:  prdata = CFG_DATA_W'(source_width_q);
			REG_SOURCE_HEIGHT: prdata = CFG_DATA_W'(source_height_q);
			REG_DEST_WIDTH:    prdata = CFG_DATA_W'(dest_width_q);
			REG_DEST_HEIGHT:   prdata = CFG_DATA_W'(dest_height_q);
			default:           prdata = '0;
		endcase
	end

	// Pipeline flow control: a stage moves when it is empty or its successor moves.
	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3    = !valid_s3 || out_ready;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign in_ready  = adv_s1;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: input register.
	logic [COORD_W-1:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			x_s1 <= dest_x;
			y_s1 <= dest_y;
		end
	end

	// Stage 2: center the pixel on half the canvas and form the products.
	logic signed [CX_W-1:0] cx, cy;
	prod_t                  prod_d, prod_s2;

	always_comb begin
		cx = $signed({1'b0, x_s1}) - $signed({2'b00, dest_width_q[DDIM_W-1:1]});
		cy = $signed({1'b0, y_s1}) - $signed({2'b00, dest_height_q[DDIM_W-1:1]});
		prod_d.x_cos = PROD_W'(cx) * PROD_W'(cos_angle_q);
		prod_d.y_sin = PROD_W'(cy) * PROD_W'(sin_angle_q);
		prod_d.x_sin = PROD_W'(cx) * PROD_W'(sin_angle_q);
		prod_d.y_cos = PROD_W'(cy) * PROD_W'(cos_angle_q);
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			prod_s2 <= prod_d;
		end
	end

	// Stage 3: sum with the pivot, floor to pixels and bound check.
	logic signed [ACC_W-1:0] ax, ay, sx, sy, w_ext, h_ext;
	logic [DIM_W-1:0]        w_sat, h_sat;
	logic                    in_src;

	always_comb begin
		ax = ACC_W'(prod_s2.x_cos) + ACC_W'(prod_s2.y_sin)
			+ (ACC_W'(pivot_x_q) <<< FRAC_BITS);
		ay = ACC_W'(prod_s2.y_cos) - ACC_W'(prod_s2.x_sin)
			+ (ACC_W'(pivot_y_q) <<< FRAC_BITS);
		sx = ax >>> FRAC_BITS;
		sy = ay >>> FRAC_BITS;
		// Source size saturates to the largest supported sprite.
		w_sat = (DIM_W'(source_width_q) > MAX_DIM) ? MAX_DIM : DIM_W'(source_width_q);
		h_sat = (DIM_W'(source_height_q) > MAX_DIM) ? MAX_DIM : DIM_W'(source_height_q);
		w_ext = $signed(ACC_W'(w_sat));
		h_ext = $signed(ACC_W'(h_sat));
		in_src = !sx[ACC_W-1] && !sy[ACC_W-1] && (sx < w_ext) && (sy < h_ext);
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			src_x      <= in_src ? sx[SRC_W-1:0] : '0;
			src_y      <= in_src ? sy[SRC_W-1:0] : '0;
			inside_res <= in_src;
		end
	end

endmodule

// ===== hdl/rssm_checker.sv =====
// Port-level checker of the rotated sprite source mapper, bound to the top level.
// Depends on rssm_pkg and rotated_sprite_source_mapper_macros.svh.
`include "rotated_sprite_source_mapper_macros.svh"

module rssm_checker
	import rssm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [SRC_W-1:0]      src_x,
	input logic [SRC_W-1:0]      src_y,
	input logic                  inside_res
);

	// Requests accepted whose results are not yet taken.
	logic [2:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// A stalled result holds its value.
	`RSSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(src_x) && $stable(src_y) && $stable(inside_res), "stalled result changed")

	// A result outside the sprite carries zero coordinates.
	`RSSM_ASSERT(a_outside_zero, out_valid && !inside_res, src_x == '0 && src_y == '0, "outside result not zero")

	// Every result belongs to an accepted request, and no more than three are in flight.
	`RSSM_ASSERT(a_no_invented, out_valid, pending_q != '0 && pending_q <= 3'd3, "result without request")

	// A free receiver never stalls the request side.
	`RSSM_ASSERT(a_ready_flow, out_ready, in_ready, "request stalled while receiver ready")

endmodule

bind rotated_sprite_source_mapper rssm_checker u_rssm_checker (.*);

// ===== sim/rotated_sprite_source_mapper_checker.sv =====
// Scoreboard for the rotated sprite source mapper: mirrors the APB writes,
// predicts one source coordinate per pixel request and compares every result.
// Depends on rssm_pkg for the register indexes and field widths.
`timescale 1ns / 1ps

module rotated_sprite_source_mapper_checker
	import rssm_pkg::*;
#(
	parameter int MAX_SOURCE_DIM = 1024,
	parameter int FRAC_BITS      = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [COORD_W-1:0]    dest_x,
	input  logic [COORD_W-1:0]    dest_y,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [SRC_W-1:0]      src_x,
	input  logic [SRC_W-1:0]      src_y,
	input  logic                  inside_res,
	output int                    fail_cnt,
	output int                    pending,
	output int                    result_cnt,
	output int                    hit_cnt
);

	typedef struct packed {
		logic [SRC_W-1:0] x;
		logic [SRC_W-1:0] y;
		logic             in_src;
	} src_point_t;

	// Shadow copy of the mapping registers.
	logic signed [TRIG_W-1:0]  cos_q;
	logic signed [TRIG_W-1:0]  sin_q;
	logic signed [PIVOT_W-1:0] pivot_x_q;
	logic signed [PIVOT_W-1:0] pivot_y_q;
	logic [SDIM_W-1:0]         src_w_q;
	logic [SDIM_W-1:0]         src_h_q;
	logic [DDIM_W-1:0]         dst_w_q;
	logic [DDIM_W-1:0]         dst_h_q;

	src_point_t src_point_q[$];
	src_point_t want;
	int         fail_total;
	int         result_total;
	int         hit_total;

	assign fail_cnt   = fail_total;
	assign result_cnt = result_total;
	assign hit_cnt    = hit_total;

	// Track register writes exactly as the block latches them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q     <= TRIG_W'(1 << FRAC_BITS);
			sin_q     <= '0;
			pivot_x_q <= '0;
			pivot_y_q <= '0;
			src_w_q   <= SDIM_W'(1);
			src_h_q   <= SDIM_W'(1);
			dst_w_q   <= '0;
			dst_h_q   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
				REG_COS_ANGLE:     cos_q     <= pwdata[TRIG_W-1:0];
				REG_SIN_ANGLE:     sin_q     <= pwdata[TRIG_W-1:0];
				REG_PIVOT_X:       pivot_x_q <= pwdata[PIVOT_W-1:0];
				REG_PIVOT_Y:       pivot_y_q <= pwdata[PIVOT_W-1:0];
				REG_SOURCE_WIDTH:  src_w_q   <= pwdata[SDIM_W-1:0];
				REG_SOURCE_HEIGHT: src_h_q   <= pwdata[SDIM_W-1:0];
				REG_DEST_WIDTH:    dst_w_q   <= pwdata[DDIM_W-1:0];
				REG_DEST_HEIGHT:   dst_h_q   <= pwdata[DDIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Inverse rotation of one destination pixel, floored to whole source pixels.
	function automatic src_point_t map_pixel(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		longint     cx;
		longint     cy;
		longint     ax;
		longint     ay;
		longint     sx;
		longint     sy;
		longint     w;
		longint     h;
		src_point_t p;
		cx = longint'(x) - longint'(dst_w_q >> 1);
		cy = longint'(y) - longint'(dst_h_q >> 1);
		ax = cx * longint'(cos_q) + cy * longint'(sin_q)
			+ longint'(pivot_x_q) * (longint'(1) <<< FRAC_BITS);
		ay = cy * longint'(cos_q) - cx * longint'(sin_q)
			+ longint'(pivot_y_q) * (longint'(1) <<< FRAC_BITS);
		sx = ax >>> FRAC_BITS;
		sy = ay >>> FRAC_BITS;
		// Oversized sprites are clipped to the largest supported dimension.
		w = (src_w_q > MAX_SOURCE_DIM) ? longint'(MAX_SOURCE_DIM) : longint'(src_w_q);
		h = (src_h_q > MAX_SOURCE_DIM) ? longint'(MAX_SOURCE_DIM) : longint'(src_h_q);
		p = '0;
		if (sx >= 0 && sy >= 0 && sx < w && sy < h) begin
			p.x      = sx[SRC_W-1:0];
			p.y      = sy[SRC_W-1:0];
			p.in_src = 1'b1;
		end
		return p;
	endfunction

	// Queue a prediction per accepted request and retire one per accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_point_q.delete();
			pending      <= 0;
			fail_total   = 0;
			result_total = 0;
			hit_total    = 0;
		end else begin
			if (in_valid && in_ready)
				src_point_q.push_back(map_pixel(dest_x, dest_y));
			if (out_valid && out_ready) begin
				result_total++;
				if (src_point_q.size() == 0) begin
					$display("%0t: result with no request outstanding: src_x %0d src_y %0d inside %0b",
						$time, src_x, src_y, inside_res);
					fail_total++;
				end else begin
					want = src_point_q.pop_front();
					if (want.in_src)
						hit_total++;
					if (src_x !== want.x) begin
						$display("%0t: src_x mismatch: expected %0d, got %0d", $time, want.x, src_x);
						fail_total++;
					end
					if (src_y !== want.y) begin
						$display("%0t: src_y mismatch: expected %0d, got %0d", $time, want.y, src_y);
						fail_total++;
					end
					if (inside_res !== want.in_src) begin
						$display("%0t: inside_res mismatch: expected %0b, got %0b",
							$time, want.in_src, inside_res);
						fail_total++;
					end
				end
			end
			pending <= src_point_q.size();
		end
	end

endmodule

// ===== sim/rotated_sprite_source_mapper_tb.sv =====
// Top of the rotated sprite source mapper testbench: clock, reset, APB setup
// and pixel request stimulus; the scoreboard module checks every result.
// Depends on rssm_pkg, rotated_sprite_source_mapper and its checker module.
`timescale 1ns / 1ps

module rotated_sprite_source_mapper_tb;
	import rssm_pkg::*;

	localparam int  MAX_DIM     = 1024;
	localparam int  FRAC        = 16;
	localparam int  CYCLE_LIMIT = 400000;
	localparam real PI          = 3.14159265358979;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [COORD_W-1:0]    dest_x = '0;
	logic [COORD_W-1:0]    dest_y = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SRC_W-1:0]      src_x;
	logic [SRC_W-1:0]      src_y;
	logic                  inside_res;

	int fail_cnt;
	int pending;
	int result_cnt;
	int hit_cnt;
	int send_idle = 0;
	int recv_stall = 0;
	int request_cnt = 0;
	int setting_cnt = 0;
	int canvas_w = 0;
	int canvas_h = 0;
	int cycle_cnt = 0;
	int idle_tab[4] = '{0, 49, 0, 35};
	int stall_tab[4] = '{0, 0, 49, 35};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rotated_sprite_source_mapper #(
		.MAX_SOURCE_DIM(MAX_DIM),
		.FRAC_BITS     (FRAC)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.src_x     (src_x),
		.src_y     (src_y),
		.inside_res(inside_res)
	);

	rotated_sprite_source_mapper_checker #(
		.MAX_SOURCE_DIM(MAX_DIM),
		.FRAC_BITS     (FRAC)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.src_x     (src_x),
		.src_y     (src_y),
		.inside_res(inside_res),
		.fail_cnt  (fail_cnt),
		.pending   (pending),
		.result_cnt(result_cnt),
		.hit_cnt   (hit_cnt)
	);

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// One APB write: setup cycle, access cycle, then the bus returns to idle.
	task automatic apb_write(input reg_idx_t idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and wait until every outstanding request has its result.
	task automatic drain;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Load a complete mapping once the pipeline is empty.
	task automatic set_mapping(input int c, input int s, input int px, input int py,
			input int sw, input int sh, input int dw, input int dh);
		drain();
		apb_write(REG_COS_ANGLE, c);
		apb_write(REG_SIN_ANGLE, s);
		apb_write(REG_PIVOT_X, px);
		apb_write(REG_PIVOT_Y, py);
		apb_write(REG_SOURCE_WIDTH, sw);
		apb_write(REG_SOURCE_HEIGHT, sh);
		apb_write(REG_DEST_WIDTH, dw);
		apb_write(REG_DEST_HEIGHT, dh);
		canvas_w = dw & 12'hFFF;
		canvas_h = dh & 12'hFFF;
		setting_cnt++;
	endtask

	// Present one pixel request and hold it until it is accepted.
	task automatic send_pixel(input int x, input int y);
		logic rdy;
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		dest_x   <= COORD_W'(x);
		dest_y   <= COORD_W'(y);
		// Sample ready at the falling edge so the decision is race free.
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		request_cnt++;
	endtask

	// A real rotation around a point of the sprite, or any register contents.
	task automatic random_mapping(input bit wild);
		real ang;
		int  c;
		int  s;
		int  sw;
		int  sh;
		int  dw;
		int  dh;
		if (wild) begin
			set_mapping(int'($urandom_range(0, 262143)) - 131072,
				int'($urandom_range(0, 262143)) - 131072,
				int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
				$urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(0, 4095), $urandom_range(0, 4095));
		end else begin
			ang = real'($urandom_range(0, 359)) * PI / 180.0;
			c   = $rtoi($cos(ang) * 65536.0);
			s   = $rtoi($sin(ang) * 65536.0);
			sw  = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
			sh  = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
			dw  = sw + sh + $urandom_range(0, 16);
			dh  = sw + sh + $urandom_range(0, 16);
			set_mapping(c, s, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
				sw, sh, dw, dh);
		end
	endtask

	// Watchdog on the total run length.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.",
			cycle_cnt, pending);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Plain copy of a full size sprite, edges of the source and of the fields.
		set_mapping(65536, 0, 0, 0, 1024, 1024, 0, 0);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(1024, 5);
		send_pixel(5, 1024);
		send_pixel(4095, 4095);
		send_pixel(2, 3);

		// Quarter turn on the largest canvas, pivot at the extremes, sprite
		// size beyond the supported maximum.
		set_mapping(0, 65536, -2048, 2047, 2047, 2047, 4095, 4095);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(3071, 2048);
		send_pixel(3071, 3100);
		send_pixel(2048, 2048);

		// Sine and cosine at the ends of the register range, one pixel sprite.
		set_mapping(131071, -131072, -2048, 2047, 1, 1, 4094, 1);
		send_pixel(2047, 0);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(100, 200);

		// Sprite of zero width.
		set_mapping(65536, 0, 0, 0, 0, 5, 0, 0);
		send_pixel(0, 0);
		send_pixel(0, 1);

		// Fractional factors with negative sums, so flooring matters.
		set_mapping(32768, -32768, 10, 10, 64, 64, 8, 8);
		send_pixel(3, 5);
		send_pixel(1, 0);
		send_pixel(0, 1);
		send_pixel(4095, 0);

		// Random pixels under four mixes of sender gaps and receiver stalls.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle  = idle_tab[ph];
			recv_stall = stall_tab[ph];
			for (int blk = 0; blk < 5; blk++) begin
				random_mapping(blk == 4);
				repeat (50) begin
					if ($urandom_range(0, 9) < 8)
						send_pixel($urandom_range(0, canvas_w), $urandom_range(0, canvas_h));
					else
						send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d pixel requests over %0d mapping settings and four flow mixes;",
			request_cnt, setting_cnt);
		$display("%0d results checked, %0d of them inside the source sprite.",
			result_cnt, hit_cnt);
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rssm_pkg.sv
hdl/rotated_sprite_source_mapper.sv
hdl/rssm_checker.sv
sim/rotated_sprite_source_mapper_checker.sv
sim/rotated_sprite_source_mapper_tb.sv
